// ===== src/scrd_pkg.sv =====
`default_nettype none

package scrd_pkg;

  // Configuration register indexes
  localparam logic CFG_REVISION = 1'b0;
  localparam logic CFG_AV_PACK  = 1'b1;

  // Board revisions
  localparam logic [1:0] REV_P01 = 2'd0;
  localparam logic [1:0] REV_P2L = 2'd1;
  localparam logic [1:0] REV_D01 = 2'd2;
  localparam logic [1:0] REV_D05 = 2'd3;

  // Access modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Command numbers
  localparam logic [7:0] CMD_VERSION   = 8'h01;
  localparam logic [7:0] CMD_RESET     = 8'h02;
  localparam logic [7:0] CMD_AV_PACK   = 8'h04;
  localparam logic [7:0] CMD_LED_MODE  = 8'h07;
  localparam logic [7:0] CMD_LED_SEQ   = 8'h08;
  localparam logic [7:0] CMD_CPU_TEMP  = 8'h09;
  localparam logic [7:0] CMD_MB_TEMP   = 8'h0A;
  localparam logic [7:0] CMD_SCRATCH   = 8'h0E;
  localparam logic [7:0] CMD_SCR_MIRR  = 8'h0F;
  localparam logic [7:0] CMD_SCRATCH2  = 8'h1B;
  localparam logic [7:0] CMD_CHAL_LO   = 8'h1C;
  localparam logic [7:0] CMD_CHAL_HI   = 8'h1F;

  // Written values with a meaning
  localparam logic [7:0] VAL_POWER_OFF  = 8'h80;
  localparam logic [7:0] VAL_LED_GREEN  = 8'h00;
  localparam logic [7:0] VAL_LED_SEQ    = 8'h01;
  localparam logic [7:0] VAL_REWIND     = 8'h00;
  localparam logic [7:0] VAL_SCR_EJECT  = 8'h01;
  localparam logic [7:0] VAL_SCR_FATAL  = 8'h02;
  localparam logic [7:0] VAL_SCR_RESET  = 8'h04;
  localparam logic [7:0] VAL_SCR_CYCLE  = 8'h08;

  localparam logic [7:0] LED_SOLID_GREEN = 8'h0F;

  typedef enum logic [1:0] {
    SEL_IMM,
    SEL_MEM,
    SEL_LED_MEM
  } src_sel_e;

  // Work held between the store read and the output register
  typedef struct packed {
    src_sel_e   sel;
    logic [7:0] imm;
    logic       led;
    logic [7:0] col;
    logic       shut;
    logic       fatal;
    logic [7:0] rst_val;
  } slot_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       led_update;
    logic [7:0] led_colours;
    logic       shutdown;
    logic       fatal;
  } result_t;

  function automatic logic [7:0] led_slots(input logic [7:0] s);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k+1] = s[7-k];
      r[2*k]   = s[3-k];
    end
    return r;
  endfunction

  function automatic logic [7:0] version_char(input logic [1:0] rev, input logic [1:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (p)
      2'd1: c = (rev == REV_D01) ? 8'h58 : 8'h30;
      2'd2: begin
        case (rev)
          REV_P01: c = 8'h31;
          REV_D01: c = 8'h42;
          default: c = 8'h35;
        endcase
      end
      default: c = (rev == REV_D01 || rev == REV_D05) ? 8'h44 : 8'h50;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] store_reset_value(input logic [7:0] addr);
    return (addr == CMD_LED_SEQ) ? LED_SOLID_GREEN : 8'h00;
  endfunction

endpackage

`default_nettype wire

// ===== src/scrd_ram.sv =====
`default_nettype none

module scrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/system_controller_register_device_unit.sv =====
// Path: an accepted request fills slot 1 (store read alongside), then the output register.
// Throughput: one request per cycle unless the output stalls; each makes at most one
//   access to the register store RAM (one read or one write port use), which sets the rate.
// Reset: control state, version position, A/V pack flag and configuration clear
//   at once; per-entry valid flags make unwritten entries read their reset value
//   (zero, LED sequence entry solid green), so no clearing pass is needed.
`default_nettype none

module system_controller_register_device_unit
  import scrd_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       mode_i,
  input  wire logic [7:0] command_i,
  input  wire logic [7:0] write_value_i,
  input  wire logic [7:0] cpu_temp_i,
  input  wire logic [7:0] board_temp_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            led_update_o,
  output logic [7:0]      led_colours_o,
  output logic            shutdown_request_o,
  output logic            fatal_error_flag_o
);

  localparam int AW = $clog2(STORE_DEPTH);

  // Configuration registers
  logic [1:0] revision_q;
  logic [7:0] av_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      revision_q <= REV_P01;
      av_code_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_REVISION) begin
        revision_q <= cfg_data_i[1:0];
      end else begin
        av_code_q <= cfg_data_i;
      end
    end
  end

  // Pipeline control: slot 1 waits on the RAM read, the output register
  // holds a finished beat until it is taken.
  logic    s1_valid_q, out_valid_q;
  slot_t   s1_q, s1_d;
  result_t out_q, out_d;
  logic    out_free, s1_move, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Small state kept in flops
  logic [1:0]             ver_pos_q, ver_pos_d;
  logic                   av_wr_q, av_wr_d;
  logic [STORE_DEPTH-1:0] ent_valid_q;
  logic                   ent_ok_q;

  // Store access request for this beat
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [1:0] ver_p;
  logic [7:0] ver_ch;

  always_comb begin
    ver_p  = (ver_pos_q > 2'd2) ? 2'd0 : ver_pos_q;
    ver_ch = version_char(revision_q, ver_p);
  end

  // Request decode
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = command_i[AW-1:0];
    ram_wdata  = write_value_i;
    ram_raddr  = command_i[AW-1:0];
    ver_pos_d  = ver_pos_q;
    av_wr_d    = av_wr_q;
    s1_d.sel   = SEL_IMM;
    s1_d.imm   = '0;
    s1_d.led   = 1'b0;
    s1_d.col   = '0;
    s1_d.shut  = 1'b0;
    s1_d.fatal = 1'b0;
    if (mode_i == MODE_READ) begin
      unique case (command_i)
        CMD_VERSION: begin
          // latch the character into its entry and advance the cursor
          ram_we    = 1'b1;
          ram_waddr = CMD_VERSION[AW-1:0];
          ram_wdata = ver_ch;
          s1_d.imm  = ver_ch;
          ver_pos_d = (ver_p == 2'd2) ? 2'd0 : ver_p + 2'd1;
        end
        CMD_AV_PACK: begin
          if (av_wr_q) begin
            ram_re   = 1'b1;
            s1_d.sel = SEL_MEM;
          end else begin
            s1_d.imm = av_code_q;
          end
        end
        CMD_CPU_TEMP: s1_d.imm = cpu_temp_i;
        CMD_MB_TEMP:  s1_d.imm = board_temp_i;
        CMD_SCR_MIRR: begin
          ram_re    = 1'b1;
          ram_raddr = CMD_SCRATCH[AW-1:0];
          s1_d.sel  = SEL_MEM;
        end
        default: begin
          if (!(command_i >= CMD_CHAL_LO && command_i <= CMD_CHAL_HI &&
                revision_q == REV_D01)) begin
            ram_re   = 1'b1;
            s1_d.sel = SEL_MEM;
          end
        end
      endcase
    end else begin
      ram_we = 1'b1;
      unique case (command_i)
        CMD_VERSION: begin
          ram_we = 1'b0;
          if (write_value_i == VAL_REWIND) begin
            ver_pos_d = 2'd0;
          end
        end
        CMD_RESET: begin
          ram_we    = 1'b0;
          s1_d.shut = (write_value_i == VAL_POWER_OFF);
        end
        CMD_AV_PACK: av_wr_d = 1'b1;
        CMD_LED_MODE: begin
          ram_we = 1'b0;
          if (write_value_i == VAL_LED_GREEN) begin
            s1_d.led = 1'b1;
            s1_d.col = led_slots(LED_SOLID_GREEN);
          end else if (write_value_i == VAL_LED_SEQ) begin
            ram_re    = 1'b1;
            ram_raddr = CMD_LED_SEQ[AW-1:0];
            s1_d.sel  = SEL_LED_MEM;
          end
        end
        CMD_SCRATCH2: begin
          if (write_value_i == VAL_SCR_EJECT || write_value_i == VAL_SCR_RESET ||
              write_value_i == VAL_SCR_CYCLE) begin
            ram_we = 1'b0;
          end else if (write_value_i == VAL_SCR_FATAL) begin
            s1_d.fatal = 1'b1;
          end
        end
        default: ;
      endcase
    end
    s1_d.rst_val = store_reset_value(8'(ram_raddr));
  end

  scrd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we && accept),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re && accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Accept side: advance small state and fill slot 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_pos_q   <= 2'd0;
      av_wr_q     <= 1'b0;
      ent_valid_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        ver_pos_q <= ver_pos_d;
        av_wr_q   <= av_wr_d;
        if (ram_we) begin
          ent_valid_q[ram_waddr] <= 1'b1;
        end
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q     <= s1_d;
      ent_ok_q <= ent_valid_q[ram_raddr];
    end
  end

  // Slot 1: merge the store word (or its reset value) into the result
  logic [7:0] mem_word;

  always_comb begin
    mem_word          = ent_ok_q ? ram_rdata : s1_q.rst_val;
    out_d.read_data   = s1_q.imm;
    out_d.led_update  = s1_q.led;
    out_d.led_colours = s1_q.col;
    out_d.shutdown    = s1_q.shut;
    out_d.fatal       = s1_q.fatal;
    unique case (s1_q.sel)
      SEL_MEM: out_d.read_data = mem_word;
      SEL_LED_MEM: begin
        out_d.led_update  = 1'b1;
        out_d.led_colours = led_slots(mem_word);
      end
      default: ;
    endcase
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_q.read_data;
  assign led_update_o       = out_q.led_update;
  assign led_colours_o      = out_q.led_colours;
  assign shutdown_request_o = out_q.shutdown;
  assign fatal_error_flag_o = out_q.fatal;

endmodule

`default_nettype wire

// ===== src/scrd_checker.sv =====
`default_nettype none

module scrd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_o,
  input wire logic       led_update_o,
  input wire logic [7:0] led_colours_o,
  input wire logic       shutdown_request_o,
  input wire logic       fatal_error_flag_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
      $stable(led_colours_o) && $stable(led_update_o))
    else $error("result beat changed while stalled");

  a_led_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !led_update_o |-> led_colours_o == 8'h00)
    else $error("LED colours without LED update");

  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(shutdown_request_o && fatal_error_flag_o) &&
      !(led_update_o && (shutdown_request_o || fatal_error_flag_o)))
    else $error("side effects from more than one command in one beat");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (led_update_o || shutdown_request_o || fatal_error_flag_o)
      |-> read_data_o == 8'h00)
    else $error("write beat returned read data");

endmodule

bind system_controller_register_device_unit scrd_checker u_scrd_checker (.*);

`default_nettype wire
